// ===== src/teq_pkg.sv =====
// Shared types and constants of the sorted timer event queue.
// No dependencies; imported by every module of the block.
package teq_pkg;

   localparam int CALLBACK_BITS = 8;
   localparam int ARG_BITS      = 32;
   localparam int OWNER_BITS    = 16;
   localparam int PORT_TIME_BITS = 32;
   localparam int DELAY_BITS    = 32;

   localparam logic [1:0] ACT_SET   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;

   typedef enum logic [1:0] {
      STATUS_FIRED  = 2'd0,
      STATUS_OK     = 2'd1,
      STATUS_REJECT = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_POP
   } cell_op_type;

   // Handed from each cell to its right neighbor.
   typedef struct packed {
      logic take;     // this cell or one to its left takes the new word
      logic rm_seen;  // the cleared handle sits here or to the left
   } cell_link_type;

   typedef struct packed {
      logic alloc;    // mark the first free slot as used
      logic dealloc;  // mark release_slot as free
   } slot_ctrl_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXPIRE
   } fsm_state_type;

endpackage

// ===== src/teq_cell.sv =====
// One position of the deadline-ordered cell row.
// Depends on teq_pkg for the cell op and neighbor link types.
module teq_cell import teq_pkg::*; #(
   parameter int TIME_BITS   = 32,
   parameter int IDX_BITS    = 4,
   parameter int HANDLE_BITS = 5
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cell_op_type              op,
   input  logic [TIME_BITS-1:0]     new_deadline,
   input  logic [CALLBACK_BITS-1:0] new_callback,
   input  logic [ARG_BITS-1:0]      new_arg,
   input  logic [OWNER_BITS-1:0]    new_owner,
   input  logic [IDX_BITS-1:0]      new_slot,
   input  logic [HANDLE_BITS-1:0]   rm_handle,
   input  cell_link_type            link_in,
   output cell_link_type            link_out,
   input  logic                     prev_valid,
   input  logic [TIME_BITS-1:0]     prev_deadline,
   input  logic [CALLBACK_BITS-1:0] prev_callback,
   input  logic [ARG_BITS-1:0]      prev_arg,
   input  logic [OWNER_BITS-1:0]    prev_owner,
   input  logic [IDX_BITS-1:0]      prev_slot,
   input  logic                     next_valid,
   input  logic [TIME_BITS-1:0]     next_deadline,
   input  logic [CALLBACK_BITS-1:0] next_callback,
   input  logic [ARG_BITS-1:0]      next_arg,
   input  logic [OWNER_BITS-1:0]    next_owner,
   input  logic [IDX_BITS-1:0]      next_slot,
   output logic                     valid,
   output logic [TIME_BITS-1:0]     deadline,
   output logic [CALLBACK_BITS-1:0] callback,
   output logic [ARG_BITS-1:0]      arg,
   output logic [OWNER_BITS-1:0]    owner,
   output logic [IDX_BITS-1:0]      slot
);

   logic                     valid_ff, valid_in;
   logic [TIME_BITS-1:0]     deadline_ff, deadline_in;
   logic [CALLBACK_BITS-1:0] callback_ff, callback_in;
   logic [ARG_BITS-1:0]      arg_ff, arg_in;
   logic [OWNER_BITS-1:0]    owner_ff, owner_in;
   logic [IDX_BITS-1:0]      slot_ff, slot_in;
   logic                     take_here;
   logic                     rm_hit;

   // Empty cells and cells due no earlier than the new word give way.
   assign take_here = !valid_ff || (deadline_ff >= new_deadline);
   assign rm_hit    = valid_ff && (HANDLE_BITS'(slot_ff) == rm_handle);

   assign link_out.take    = link_in.take || take_here;
   assign link_out.rm_seen = link_in.rm_seen || rm_hit;

   always_comb begin
      valid_in    = valid_ff;
      deadline_in = deadline_ff;
      callback_in = callback_ff;
      arg_in      = arg_ff;
      owner_in    = owner_ff;
      slot_in     = slot_ff;
      unique case (op)
         CELL_INSERT: begin
            if (link_in.take) begin
               valid_in    = prev_valid;
               deadline_in = prev_deadline;
               callback_in = prev_callback;
               arg_in      = prev_arg;
               owner_in    = prev_owner;
               slot_in     = prev_slot;
            end else if (take_here) begin
               valid_in    = 1'b1;
               deadline_in = new_deadline;
               callback_in = new_callback;
               arg_in      = new_arg;
               owner_in    = new_owner;
               slot_in     = new_slot;
            end
         end
         CELL_REMOVE, CELL_POP: begin
            if (op == CELL_POP || link_out.rm_seen) begin
               valid_in    = next_valid;
               deadline_in = next_deadline;
               callback_in = next_callback;
               arg_in      = next_arg;
               owner_in    = next_owner;
               slot_in     = next_slot;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      deadline_ff <= deadline_in;
      callback_ff <= callback_in;
      arg_ff      <= arg_in;
      owner_ff    <= owner_in;
      slot_ff     <= slot_in;
   end

   assign valid    = valid_ff;
   assign deadline = deadline_ff;
   assign callback = callback_ff;
   assign arg      = arg_ff;
   assign owner    = owner_ff;
   assign slot     = slot_ff;

endmodule

// ===== src/teq_slot_alloc.sv =====
// Slot-in-use bitmap with lowest-free-slot search.
// Depends on teq_pkg for the slot control struct.
module teq_slot_alloc import teq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int IDX_BITS    = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  slot_ctrl_type       ctrl,
   input  logic [IDX_BITS-1:0] release_slot,
   output logic [IDX_BITS-1:0] free_slot
);

   logic [QUEUE_DEPTH-1:0] in_use_ff, in_use_in;

   always_comb begin
      free_slot = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_slot = IDX_BITS'(i);
         end
      end
   end

   always_comb begin
      in_use_in = in_use_ff;
      if (ctrl.alloc) begin
         in_use_in[free_slot] = 1'b1;
      end
      if (ctrl.dealloc) begin
         in_use_in[release_slot] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         in_use_ff <= in_use_in;
      end
   end

endmodule

// ===== src/sorted_timer_event_queue.sv =====
// Sorted timer event queue: holds up to QUEUE_DEPTH timer events in a row of
// cells kept in deadline order, head in cell 0. A request word either sets an
// event (due at now_time + interval, saturated at the top of the time range,
// placed ahead of equal deadlines), clears an event by handle, or only ticks.
// The set or clear happens in the cycle the word is accepted, as one shift of
// the whole cell row. From the next cycle on the head is checked once a cycle
// against the word's now_time and popped while it is due or belongs to
// another owner; each popped event of the current owner gives a fired
// response word, others vanish silently. The check that finds nothing to pop
// sends the closing word (last = 1) with status, the new handle of a set, and
// the delay to the new head. Handles are slot numbers; the lowest free slot is
// taken. The owner register must be written only between items; the block
// itself does not enforce it. Reset clears the cell valid bits and the slot
// bitmap; there is no clearing pass.
module sorted_timer_event_queue import teq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int TIME_BITS   = 32,
   localparam int IDX_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
   localparam int HANDLE_BITS = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   // configuration
   input  logic                      csr_write_en,
   input  logic [OWNER_BITS-1:0]     csr_write_data,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_action,
   input  logic [PORT_TIME_BITS-1:0] req_now_time,
   input  logic [PORT_TIME_BITS-1:0] req_interval,
   input  logic [CALLBACK_BITS-1:0]  req_callback_id,
   input  logic [ARG_BITS-1:0]       req_callback_arg,
   input  logic [HANDLE_BITS-1:0]    req_clear_handle,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [HANDLE_BITS-1:0]    rsp_event_handle,
   output logic [CALLBACK_BITS-1:0]  rsp_fired_callback,
   output logic [ARG_BITS-1:0]       rsp_fired_arg,
   output logic [DELAY_BITS-1:0]     rsp_alarm_delay,
   output logic                      rsp_last
);

   localparam logic [HANDLE_BITS-1:0] NO_HANDLE = HANDLE_BITS'(QUEUE_DEPTH);

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   fsm_state_type             state_ff, state_in;
   logic [OWNER_BITS-1:0]     owner_ff;
   logic [TIME_BITS-1:0]      now_ff;
   status_type                status_ff, status_in;
   logic [HANDLE_BITS-1:0]    handle_ff, handle_in;

   // Output register, parts the queue from the response side.
   logic                      rsp_valid_ff;
   status_type                rsp_status_ff;
   logic [HANDLE_BITS-1:0]    rsp_handle_ff;
   logic [CALLBACK_BITS-1:0]  rsp_callback_ff;
   logic [ARG_BITS-1:0]       rsp_arg_ff;
   logic [DELAY_BITS-1:0]     rsp_delay_ff;
   logic                      rsp_last_ff;

   // ---------------------------------------------------------------------
   // Cell row wiring
   // ---------------------------------------------------------------------
   cell_op_type               cell_op;
   slot_ctrl_type             slot_ctrl;
   logic [IDX_BITS-1:0]       release_slot;
   logic [IDX_BITS-1:0]       free_slot;

   logic                      c_valid    [QUEUE_DEPTH];
   logic [TIME_BITS-1:0]      c_deadline [QUEUE_DEPTH];
   logic [CALLBACK_BITS-1:0]  c_callback [QUEUE_DEPTH];
   logic [ARG_BITS-1:0]       c_arg      [QUEUE_DEPTH];
   logic [OWNER_BITS-1:0]     c_owner    [QUEUE_DEPTH];
   logic [IDX_BITS-1:0]       c_slot     [QUEUE_DEPTH];
   cell_link_type             c_link     [QUEUE_DEPTH];

   // ---------------------------------------------------------------------
   // Request decode: mask times to TIME_BITS, saturate the new deadline
   // ---------------------------------------------------------------------
   logic [63:0]               now_wide, intv_wide;
   logic [TIME_BITS-1:0]      req_now, req_intv, new_due;
   logic [TIME_BITS:0]        due_sum;
   logic                      accept, queue_full;

   assign now_wide  = 64'(req_now_time);
   assign intv_wide = 64'(req_interval);
   assign req_now   = now_wide[TIME_BITS-1:0];
   assign req_intv  = intv_wide[TIME_BITS-1:0];
   assign due_sum   = {1'b0, req_now} + {1'b0, req_intv};
   assign new_due   = due_sum[TIME_BITS] ? '1 : due_sum[TIME_BITS-1:0];

   assign queue_full = c_valid[QUEUE_DEPTH-1];
   assign req_stall  = (state_ff != ST_IDLE);
   assign accept     = req_valid && !req_stall;

   // ---------------------------------------------------------------------
   // Head check: due or foreign-owned heads are popped
   // ---------------------------------------------------------------------
   logic                      head_owned, head_pop, out_free;
   logic [TIME_BITS-1:0]      head_diff;
   logic [63:0]               diff_wide;
   logic [DELAY_BITS-1:0]     head_delay;

   assign head_owned = (c_owner[0] == owner_ff);
   assign head_pop   = c_valid[0] && ((c_deadline[0] <= now_ff) || !head_owned);
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign head_diff  = c_deadline[0] - now_ff;
   assign diff_wide  = 64'(head_diff);
   assign head_delay = (diff_wide[63:DELAY_BITS] != '0) ? '1 : diff_wide[DELAY_BITS-1:0];

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXPIRE;
            end
         end
         ST_EXPIRE: begin
            // Leave once the closing word goes into the output register.
            if (out_free && !head_pop) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Outputs of the sequencer: cell op, slot bitmap, response load
   // ---------------------------------------------------------------------
   logic                      rsp_load;
   status_type                rsp_status_in;
   logic [HANDLE_BITS-1:0]    rsp_handle_in;
   logic [CALLBACK_BITS-1:0]  rsp_callback_in;
   logic [ARG_BITS-1:0]       rsp_arg_in;
   logic [DELAY_BITS-1:0]     rsp_delay_in;
   logic                      rsp_last_in;

   always_comb begin
      cell_op         = CELL_HOLD;
      slot_ctrl       = '0;
      release_slot    = req_clear_handle[IDX_BITS-1:0];
      status_in       = STATUS_OK;
      handle_in       = NO_HANDLE;
      rsp_load        = 1'b0;
      rsp_status_in   = STATUS_FIRED;
      rsp_handle_in   = NO_HANDLE;
      rsp_callback_in = '0;
      rsp_arg_in      = '0;
      rsp_delay_in    = '0;
      rsp_last_in     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_SET: begin
                     if (req_intv == '0) begin
                        status_in = STATUS_REJECT;
                     end else if (queue_full) begin
                        status_in = STATUS_FULL;
                     end else begin
                        // Shift-insert the new event and take the lowest free slot.
                        cell_op         = CELL_INSERT;
                        slot_ctrl.alloc = 1'b1;
                        handle_in       = HANDLE_BITS'(free_slot);
                     end
                  end
                  ACT_CLEAR: begin
                     // Close the gap behind the matching cell; unknown handles hit nothing.
                     cell_op           = CELL_REMOVE;
                     slot_ctrl.dealloc = c_link[QUEUE_DEPTH-1].rm_seen;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EXPIRE: begin
            if (head_pop) begin
               // Drop foreign events at once; hold own ones until the output is free.
               if (!head_owned || out_free) begin
                  cell_op           = CELL_POP;
                  slot_ctrl.dealloc = 1'b1;
                  release_slot      = c_slot[0];
                  rsp_load          = head_owned;
                  rsp_handle_in     = HANDLE_BITS'(c_slot[0]);
                  rsp_callback_in   = c_callback[0];
                  rsp_arg_in        = c_arg[0];
               end
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = status_ff;
               rsp_handle_in = handle_ff;
               rsp_delay_in  = c_valid[0] ? head_delay : '0;
               rsp_last_in   = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         owner_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_en) begin
            owner_ff <= csr_write_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff    <= req_now;
         status_ff <= status_in;
         handle_ff <= handle_in;
      end
      if (rsp_load) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_handle_ff   <= rsp_handle_in;
         rsp_callback_ff <= rsp_callback_in;
         rsp_arg_ff      <= rsp_arg_in;
         rsp_delay_ff    <= rsp_delay_in;
         rsp_last_ff     <= rsp_last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_event_handle   = rsp_handle_ff;
   assign rsp_fired_callback = rsp_callback_ff;
   assign rsp_fired_arg      = rsp_arg_ff;
   assign rsp_alarm_delay    = rsp_delay_ff;
   assign rsp_last           = rsp_last_ff;

   // ---------------------------------------------------------------------
   // Slot bitmap
   // ---------------------------------------------------------------------
   teq_slot_alloc #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .IDX_BITS    (IDX_BITS)
   ) u_slot_alloc (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (slot_ctrl),
      .release_slot (release_slot),
      .free_slot    (free_slot)
   );

   // ---------------------------------------------------------------------
   // Cell row: cell 0 is the head; each cell talks to its two neighbors
   // ---------------------------------------------------------------------
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      cell_link_type            link_in;
      logic                     prev_valid, next_valid;
      logic [TIME_BITS-1:0]     prev_deadline, next_deadline;
      logic [CALLBACK_BITS-1:0] prev_callback, next_callback;
      logic [ARG_BITS-1:0]      prev_arg, next_arg;
      logic [OWNER_BITS-1:0]    prev_owner, next_owner;
      logic [IDX_BITS-1:0]      prev_slot, next_slot;

      if (i == 0) begin : g_first
         assign link_in       = '0;
         assign prev_valid    = 1'b0;
         assign prev_deadline = new_due;
         assign prev_callback = req_callback_id;
         assign prev_arg      = req_callback_arg;
         assign prev_owner    = owner_ff;
         assign prev_slot     = free_slot;
      end else begin : g_inner
         assign link_in       = c_link[i-1];
         assign prev_valid    = c_valid[i-1];
         assign prev_deadline = c_deadline[i-1];
         assign prev_callback = c_callback[i-1];
         assign prev_arg      = c_arg[i-1];
         assign prev_owner    = c_owner[i-1];
         assign prev_slot     = c_slot[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign next_valid    = 1'b0;
         assign next_deadline = c_deadline[i];
         assign next_callback = c_callback[i];
         assign next_arg      = c_arg[i];
         assign next_owner    = c_owner[i];
         assign next_slot     = c_slot[i];
      end else begin : g_body
         assign next_valid    = c_valid[i+1];
         assign next_deadline = c_deadline[i+1];
         assign next_callback = c_callback[i+1];
         assign next_arg      = c_arg[i+1];
         assign next_owner    = c_owner[i+1];
         assign next_slot     = c_slot[i+1];
      end

      teq_cell #(
         .TIME_BITS   (TIME_BITS),
         .IDX_BITS    (IDX_BITS),
         .HANDLE_BITS (HANDLE_BITS)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .op            (cell_op),
         .new_deadline  (new_due),
         .new_callback  (req_callback_id),
         .new_arg       (req_callback_arg),
         .new_owner     (owner_ff),
         .new_slot      (free_slot),
         .rm_handle     (req_clear_handle),
         .link_in       (link_in),
         .link_out      (c_link[i]),
         .prev_valid    (prev_valid),
         .prev_deadline (prev_deadline),
         .prev_callback (prev_callback),
         .prev_arg      (prev_arg),
         .prev_owner    (prev_owner),
         .prev_slot     (prev_slot),
         .next_valid    (next_valid),
         .next_deadline (next_deadline),
         .next_callback (next_callback),
         .next_arg      (next_arg),
         .next_owner    (next_owner),
         .next_slot     (next_slot),
         .valid         (c_valid[i]),
         .deadline      (c_deadline[i]),
         .callback      (c_callback[i]),
         .arg           (c_arg[i]),
         .owner         (c_owner[i]),
         .slot          (c_slot[i])
      );
   end

endmodule

// ===== src/teq_checker.sv =====
// Port-level checks of the sorted timer event queue, bound to its top level.
// Depends on teq_pkg for the status codes.
module teq_checker import teq_pkg::*; #(
   parameter int QUEUE_DEPTH = 16,
   parameter int HANDLE_BITS = 5
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [1:0]             rsp_status,
   input logic [HANDLE_BITS-1:0] rsp_event_handle,
   input logic [DELAY_BITS-1:0]  rsp_alarm_delay,
   input logic                   rsp_last
);

   localparam logic [HANDLE_BITS-1:0] NO_HANDLE = HANDLE_BITS'(QUEUE_DEPTH);

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_last)
         && $stable(rsp_event_handle) && $stable(rsp_alarm_delay))
      else $error("response word changed while stalled");

   // After an accepted request the block stalls its request side; no two requests are taken in a row.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken twice in a row");

   // Only fired words come before the closing word, and they carry no delay.
   a_fired_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_status == STATUS_FIRED && rsp_alarm_delay == '0)
      else $error("non-closing word is not a fired event");

   // Rejected or refused sets return no handle.
   a_reject_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && (rsp_status == STATUS_REJECT || rsp_status == STATUS_FULL)
         |-> rsp_event_handle == NO_HANDLE)
      else $error("rejected set returned a handle");

   // A fired event always names a real slot.
   a_fired_handle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FIRED |-> rsp_event_handle < NO_HANDLE && !rsp_last)
      else $error("fired word with bad handle or closing flag");

endmodule

bind sorted_timer_event_queue teq_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH),
   .HANDLE_BITS (HANDLE_BITS)
) u_teq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_event_handle (rsp_event_handle),
   .rsp_alarm_delay  (rsp_alarm_delay),
   .rsp_last         (rsp_last)
);

// ===== tb/tb_top.sv =====
// Self-checking bench for sorted_timer_event_queue: directed and random request
// words, predicted responses compared field by field. Needs only teq_pkg and
// the queue RTL.
`timescale 1ns / 100ps

module tb_top import teq_pkg::*; ();

   localparam int          QDEPTH       = 16;
   localparam logic [4:0]  NO_HANDLE    = 5'd16;
   localparam logic [1:0]  ACT_SPARE    = 2'd3;   // unused code, acts as a tick
   localparam int          RESET_CYCLES = 11;
   localparam int          IDLE_PCT     = 16;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          DRAIN_CYCLES = 40;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          REPORT_MAX   = 10;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] now_time;
      logic [31:0] interval;
      logic [7:0]  callback_id;
      logic [31:0] callback_arg;
      logic [4:0]  clear_handle;
   } timer_req_type;

   typedef struct packed {
      status_type  status;
      logic [4:0]  handle;
      logic [7:0]  callback;
      logic [31:0] arg;
      logic [31:0] delay;
      logic        last;
   } timer_rsp_type;

   // DUT ports
   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [15:0] csr_write_data;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [31:0] req_now_time;
   logic [31:0] req_interval;
   logic [7:0]  req_callback_id;
   logic [31:0] req_callback_arg;
   logic [4:0]  req_clear_handle;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_event_handle;
   logic [7:0]  rsp_fired_callback;
   logic [31:0] rsp_fired_arg;
   logic [31:0] rsp_alarm_delay;
   logic        rsp_last;

   // Shadow copy of the event queue, kept in step with accepted request words
   logic [31:0] ev_deadline [QDEPTH];
   logic [7:0]  ev_callback [QDEPTH];
   logic [31:0] ev_arg      [QDEPTH];
   logic [15:0] ev_owner    [QDEPTH];
   logic        ev_busy     [QDEPTH];
   logic [3:0]  ev_order    [QDEPTH];   // slots in deadline order, head first
   int          ev_count;
   logic [15:0] owner_reg;

   // Responses predicted but not yet seen on the response channel
   timer_rsp_type awaited_rsp[$];
   timer_rsp_type rsp_got;
   timer_rsp_type rsp_want;

   // Run bookkeeping
   logic [31:0] stim_now;
   bit          quiet_mode;
   int          stall_requests;
   int          stall_served = 0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          mismatch_count = 0;
   int          sets_sent, clears_sent, ticks_sent;
   int          fired_checked = 0;
   int          closing_checked = 0;

   sorted_timer_event_queue #(
      .QUEUE_DEPTH (QDEPTH),
      .TIME_BITS   (32)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_now_time       (req_now_time),
      .req_interval       (req_interval),
      .req_callback_id    (req_callback_id),
      .req_callback_arg   (req_callback_arg),
      .req_clear_handle   (req_clear_handle),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_event_handle   (rsp_event_handle),
      .rsp_fired_callback (rsp_fired_callback),
      .rsp_fired_arg      (rsp_fired_arg),
      .rsp_alarm_delay    (rsp_alarm_delay),
      .rsp_last           (rsp_last)
   );

   always #10 clock = ~clock;

   // Give up on a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: timeout after %0d cycles, %0d responses still awaited",
                  cycle_count, awaited_rsp.size());
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Response-side stall: random stalls, none in quiet mode, and a long
   // counted hold-off whenever the stimulus bumps stall_requests.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_served != stall_requests) begin
         stall_served <= stall_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_stall    <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet_mode && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Check every accepted response word against the oldest awaited one.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_got.status   = status_type'(rsp_status);
         rsp_got.handle   = rsp_event_handle;
         rsp_got.callback = rsp_fired_callback;
         rsp_got.arg      = rsp_fired_arg;
         rsp_got.delay    = rsp_alarm_delay;
         rsp_got.last     = rsp_last;
         if (awaited_rsp.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("tb_top: unexpected response st=%0d h=%0d cb=%h arg=%h dly=%h last=%b",
                        rsp_got.status, rsp_got.handle, rsp_got.callback, rsp_got.arg,
                        rsp_got.delay, rsp_got.last);
         end else begin
            rsp_want = awaited_rsp.pop_front();
            if (rsp_want.last)
               closing_checked++;
            else
               fired_checked++;
            if (rsp_got.status   !== rsp_want.status   ||
                rsp_got.handle   !== rsp_want.handle   ||
                rsp_got.callback !== rsp_want.callback ||
                rsp_got.arg      !== rsp_want.arg      ||
                rsp_got.delay    !== rsp_want.delay    ||
                rsp_got.last     !== rsp_want.last) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("tb_top: mismatch at cycle %0d", cycle_count);
                  $display("   expected st=%0d h=%0d cb=%h arg=%h dly=%h last=%b",
                           rsp_want.status, rsp_want.handle, rsp_want.callback,
                           rsp_want.arg, rsp_want.delay, rsp_want.last);
                  $display("   actual   st=%0d h=%0d cb=%h arg=%h dly=%h last=%b",
                           rsp_got.status, rsp_got.handle, rsp_got.callback,
                           rsp_got.arg, rsp_got.delay, rsp_got.last);
               end
            end
         end
      end
   end

   // Advance the shadow queue by one accepted request word and queue up the
   // responses it must produce: fired words first, then the closing word.
   task automatic step_timer_queue(input timer_req_type w);
      status_type    st;
      logic [4:0]    new_handle;
      logic [32:0]   sum;
      logic [31:0]   due;
      logic [31:0]   gap;
      int            slot, pos, p, s;
      bit            popping;
      timer_rsp_type r;
      st         = STATUS_OK;
      new_handle = NO_HANDLE;
      if (w.action == ACT_SET) begin
         if (w.interval == 32'd0) begin
            st = STATUS_REJECT;
         end else if (ev_count >= QDEPTH) begin
            st = STATUS_FULL;
         end else begin
            // saturate the deadline at the top of the time range
            sum  = {1'b0, w.now_time} + {1'b0, w.interval};
            due  = sum[32] ? '1 : sum[31:0];
            slot = 0;
            while (slot < QDEPTH && ev_busy[slot])
               slot++;
            // go in ahead of any equal deadline
            pos = 0;
            while (pos < ev_count && ev_deadline[ev_order[pos]] < due)
               pos++;
            for (p = ev_count; p > pos; p--)
               ev_order[p] = ev_order[p-1];
            ev_order[pos]     = slot[3:0];
            ev_count++;
            ev_busy[slot]     = 1'b1;
            ev_deadline[slot] = due;
            ev_callback[slot] = w.callback_id;
            ev_arg[slot]      = w.callback_arg;
            ev_owner[slot]    = owner_reg;
            new_handle        = slot[4:0];
         end
      end else if (w.action == ACT_CLEAR) begin
         // unknown or free handles leave the queue alone
         if (w.clear_handle < QDEPTH && ev_busy[w.clear_handle]) begin
            pos = -1;
            for (p = 0; p < ev_count; p++)
               if (ev_order[p] == w.clear_handle[3:0])
                  pos = p;
            for (p = pos; p < ev_count - 1; p++)
               ev_order[p] = ev_order[p+1];
            ev_count--;
            ev_busy[w.clear_handle] = 1'b0;
         end
      end

      // Expire: pop the head while it is due or owned by someone else
      popping = 1'b1;
      while (popping && ev_count > 0) begin
         s = int'(ev_order[0]);
         if (ev_deadline[s] > w.now_time && ev_owner[s] == owner_reg) begin
            popping = 1'b0;
         end else begin
            for (p = 0; p < ev_count - 1; p++)
               ev_order[p] = ev_order[p+1];
            ev_count--;
            ev_busy[s] = 1'b0;
            if (ev_owner[s] == owner_reg) begin
               r.status   = STATUS_FIRED;
               r.handle   = s[4:0];
               r.callback = ev_callback[s];
               r.arg      = ev_arg[s];
               r.delay    = '0;
               r.last     = 1'b0;
               awaited_rsp.push_back(r);
            end
         end
      end

      gap = '0;
      if (ev_count > 0)
         gap = ev_deadline[ev_order[0]] - w.now_time;
      r.status   = st;
      r.handle   = new_handle;
      r.callback = '0;
      r.arg      = '0;
      r.delay    = gap;
      r.last     = 1'b1;
      awaited_rsp.push_back(r);
   endtask

   // Offer one request word, idling first now and then; return once accepted.
   task automatic send_word(input timer_req_type w);
      while (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_action       <= w.action;
      req_now_time     <= w.now_time;
      req_interval     <= w.interval;
      req_callback_id  <= w.callback_id;
      req_callback_arg <= w.callback_arg;
      req_clear_handle <= w.clear_handle;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      step_timer_queue(w);
      case (w.action)
         ACT_SET:   sets_sent++;
         ACT_CLEAR: clears_sent++;
         default:   ticks_sent++;
      endcase
   endtask

   // Drop valid and hold until every awaited response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_rsp.size() != 0)
         @(posedge clock);
   endtask

   // Write the owner register; only done with the queue block idle.
   task automatic write_owner(input logic [15:0] owner);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= owner;
      @(posedge clock);
      csr_write_en <= 1'b0;
      owner_reg     = owner;
   endtask

   function automatic timer_req_type make_word(input logic [1:0] act,
                                               input logic [31:0] now_t,
                                               input logic [31:0] intv,
                                               input logic [7:0] cb,
                                               input logic [31:0] arg,
                                               input logic [4:0] h);
      timer_req_type w;
      w.action       = act;
      w.now_time     = now_t;
      w.interval     = intv;
      w.callback_id  = cb;
      w.callback_arg = arg;
      w.clear_handle = h;
      return w;
   endfunction

   // Mostly a well-behaved clock with short intervals, so events get queued,
   // cleared and fired; now and then jumps, step-backs and extreme values.
   function automatic timer_req_type random_word();
      timer_req_type w;
      int            roll;
      int            start;
      int            k;
      roll = $urandom_range(99);
      if (roll < 4)
         stim_now = $urandom;
      else if (roll < 6)
         stim_now = '1;
      else if (roll < 8)
         stim_now = stim_now - $urandom_range(500);
      else
         stim_now = stim_now + $urandom_range(40);
      w.now_time     = stim_now;
      w.callback_id  = 8'($urandom);
      w.callback_arg = $urandom;

      roll = $urandom_range(99);
      if (roll < 85)
         w.interval = $urandom_range(300, 1);
      else if (roll < 90)
         w.interval = '0;
      else if (roll < 95)
         w.interval = $urandom;
      else
         w.interval = '1;

      // clears mostly hit a live handle; the rest are random and may be unknown or out of range
      roll = $urandom_range(99);
      w.clear_handle = 5'($urandom_range(16));
      if (roll >= 90) begin
         w.clear_handle = 5'($urandom_range(31));
      end else if (roll < 70) begin
         start = $urandom_range(QDEPTH - 1);
         for (k = 0; k < QDEPTH; k++)
            if (ev_busy[(start + k) % QDEPTH])
               w.clear_handle = 5'((start + k) % QDEPTH);
      end

      roll = $urandom_range(99);
      if (roll < 48)
         w.action = ACT_SET;
      else if (roll < 70)
         w.action = ACT_CLEAR;
      else if (roll < 94)
         w.action = ACT_TICK;
      else
         w.action = ACT_SPARE;
      return w;
   endfunction

   // Rejected set, field extremes, clears of out-of-range and live handles, the
   // spare action code, and a saturated deadline that fires in
   // the same word that set it.
   task automatic test_directed_ops();
      send_word(make_word(ACT_SET,   32'd0,   32'd0,  8'h00, 32'h0, NO_HANDLE));
      send_word(make_word(ACT_SET,   32'd100, 32'd50, 8'hFF, '1,    NO_HANDLE));
      send_word(make_word(ACT_CLEAR, 32'd110, 32'd0,  8'h00, 32'h0, NO_HANDLE));
      send_word(make_word(ACT_CLEAR, 32'd120, 32'd0,  8'h00, 32'h0, 5'd31));
      send_word(make_word(ACT_CLEAR, 32'd130, 32'd0,  8'h00, 32'h0, 5'd0));
      send_word(make_word(ACT_SPARE, 32'd200, 32'd0,  8'h00, 32'h0, NO_HANDLE));
      send_word(make_word(ACT_SET,   '1,      32'd1,  8'h00, 32'h0, NO_HANDLE));
   endtask

   // Fill all slots (deadlines in three repeating values, one saturated), bounce off the full queue
   // while the events due by then fire, then fire the rest in one word for the longest response burst.
   task automatic test_queue_full();
      int n;
      write_owner(16'hFFFF);
      for (n = 0; n < QDEPTH - 1; n++)
         send_word(make_word(ACT_SET, 32'd1000, (n % 3) + 1, 8'(n), $urandom, NO_HANDLE));
      send_word(make_word(ACT_SET, 32'd1000, '1, 8'hA5, $urandom, NO_HANDLE));
      send_word(make_word(ACT_SET, 32'd1001, 32'd5, 8'h5A, $urandom, NO_HANDLE));
      send_word(make_word(ACT_TICK, '1, 32'd0, 8'h00, 32'h0, NO_HANDLE));
   endtask

   // One phase of random traffic under a fresh owner; events left over from
   // the previous owner get flushed silently as they reach the head.
   task automatic test_random_traffic(input logic [15:0] owner, input int words,
                                      input bit no_idle);
      int n;
      write_owner(owner);
      quiet_mode <= no_idle;
      for (n = 0; n < words; n++)
         send_word(random_word());
   endtask

   // Hold the response side off for a long stretch while requests keep
   // coming, so the block backs up and stalls its request side.
   task automatic test_backpressure();
      int n;
      wait_drained();
      quiet_mode     <= 1'b1;
      stall_requests <= stall_requests + 1;
      for (n = 0; n < 30; n++)
         send_word(random_word());
      quiet_mode <= 1'b0;
   endtask

   initial begin
      clock            = 1'b0;
      reset            = 1'b1;
      csr_write_en     = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_action       = ACT_TICK;
      req_now_time     = '0;
      req_interval     = '0;
      req_callback_id  = '0;
      req_callback_arg = '0;
      req_clear_handle = NO_HANDLE;
      ev_busy          = '{default: 1'b0};
      ev_count         = 0;
      owner_reg        = '0;
      stim_now         = 32'd5000;
      quiet_mode       = 1'b0;
      stall_requests   = 0;
      sets_sent        = 0;
      clears_sent      = 0;
      ticks_sent       = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_queue_full();
      test_random_traffic(16'h0000, 75, 1'b0);
      test_random_traffic(16'hFFFF, 75, 1'b1);    // long stretch with no idling
      test_random_traffic(16'($urandom), 75, 1'b0);
      test_backpressure();
      test_random_traffic(16'($urandom), 75, 1'b0);
      test_random_traffic(16'h0000, 75, 1'b0);

      // let the tail drain, then give stray words time to show up
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb_top: sent %0d sets, %0d clears, %0d ticks over six owner settings",
               sets_sent, clears_sent, ticks_sent);
      $display("tb_top: checked %0d fired and %0d closing responses, %0d mismatches",
               fired_checked, closing_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule
